// ===== rtl/core/itx_pkg.sv =====
// Shared types and constants of the indexed texel expander.
// No dependencies; used by the top level and by the testbench.
package itx_pkg;

	typedef enum logic [1:0] {
		CMD_PALETTE = 2'd0,
		CMD_PIXEL   = 2'd1,
		CMD_DRAIN   = 2'd2
	} cmd_t;

	localparam logic [7:0] HOLE_INDEX = 8'hff;

	localparam int CFG_W = 11;
	localparam int IDX_W = 1;
	localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	localparam int RESET_WIDTH  = 64;
	localparam int RESET_HEIGHT = 64;

	localparam int S_DATA_W = 40;
	localparam int M_DATA_W = 24;
	localparam int PAL_W    = 24;

	typedef struct packed {
		logic first;
		logic above_ok;
		logic below_ok;
		logic prev_ok;
		logic next_ok;
		logic last;
		logic fwd;
	} emit_ctl_t;

endpackage

// ===== rtl/core/indexed_texel_expand_with_hole_fill.sv =====
// Top level of the indexed texel expander with transparent-hole fill.
// Depends on itx_pkg and itx_ram.
//
// While s_tready is high the block takes one request per clock: palette writes, raster
// pixel indices and drain requests. A pixel is expanded once the pixel one row below it has
// arrived, so results trail the input by one row, and drain requests release the last row.
// A result comes from the registered read of the index window memory followed by the
// registered read of the palette memory. The index window holds 2*MAX_WIDTH+1 raw indices
// and is kept in two copies, one per read port. A transparent index takes the first opaque
// raw neighbor above, below, before or after it, else entry 0.
module indexed_texel_expand_with_hole_fill #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [itx_pkg::IDX_W-1:0]     cfg_index,
	input  logic [itx_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// pixel_index, entry_number, entry_red, entry_green, entry_blue
	input  logic [itx_pkg::S_DATA_W-1:0]  s_tdata,
	// cmd
	input  logic [1:0]                    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// red, green, blue
	output logic [itx_pkg::M_DATA_W-1:0]  m_tdata,
	output logic                          m_tlast
);

	localparam int WW      = $clog2(MAX_WIDTH + 1);
	localparam int HW      = $clog2(MAX_HEIGHT + 1);
	localparam int CNT_W   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
	localparam int WIN_D   = 2 * MAX_WIDTH + 1;
	localparam int WIN_AW  = $clog2(WIN_D);
	localparam int RST_W   = (itx_pkg::RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH
		: itx_pkg::RESET_WIDTH;
	localparam int RST_H   = (itx_pkg::RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT
		: itx_pkg::RESET_HEIGHT;
	localparam int RST_TOT = RST_W * RST_H;

	function automatic logic [WW-1:0] clamp_w(input logic [itx_pkg::CFG_W-1:0] v);
		logic [WW-1:0] r;
		if (v == '0) begin
			r = WW'(1);
		end else if (int'(v) > MAX_WIDTH) begin
			r = WW'(MAX_WIDTH);
		end else begin
			r = WW'(v);
		end
		return r;
	endfunction

	function automatic logic [HW-1:0] clamp_h(input logic [itx_pkg::CFG_W-1:0] v);
		logic [HW-1:0] r;
		if (v == '0) begin
			r = HW'(1);
		end else if (int'(v) > MAX_HEIGHT) begin
			r = HW'(MAX_HEIGHT);
		end else begin
			r = HW'(v);
		end
		return r;
	endfunction

	function automatic logic [WIN_AW-1:0] win_inc(input logic [WIN_AW-1:0] a);
		logic [WIN_AW-1:0] r;
		if (a == WIN_AW'(WIN_D - 1)) begin
			r = '0;
		end else begin
			r = a + WIN_AW'(1);
		end
		return r;
	endfunction

	logic [WW-1:0]     eff_w_q;
	logic [HW-1:0]     eff_h_q;
	logic [CNT_W-1:0]  total_q;
	logic [CNT_W-1:0]  recv_q;
	logic [CNT_W-1:0]  emit_q;
	logic [WIN_AW-1:0] wr_addr_q;
	logic [WIN_AW-1:0] nx_addr_q;

	itx_pkg::cmd_t     cmd;
	logic              s_fire;
	logic              full;
	logic              done;
	logic              pix_take;
	logic              emit_go;
	logic [CNT_W-1:0]  emit_p1;
	logic [WIN_AW-1:0] wr_addr_now;
	logic [WIN_AW:0]   above_diff;
	logic [WIN_AW-1:0] above_addr;
	logic [WIN_AW-1:0] rd_b_addr;
	itx_pkg::emit_ctl_t ctl_now;

	logic              v_s1;
	itx_pkg::emit_ctl_t ctl_s1;
	logic [7:0]        pix_s1;
	logic [7:0]        cur_q;
	logic [7:0]        nxt_q;
	logic [7:0]        win_a_rd;
	logic [7:0]        win_b_rd;
	logic [7:0]        cur_v;
	logic [7:0]        nxt_v;
	logic [7:0]        pal_idx;
	logic              adv1;

	logic              v_s2;
	logic              last_s2;

	// Configuration registers and the product that bounds one image.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_w_q <= WW'(RST_W);
			eff_h_q <= HW'(RST_H);
			total_q <= CNT_W'(RST_TOT);
		end else if (cfg_we) begin
			case (cfg_index)
				itx_pkg::REG_IMAGE_WIDTH: begin
					eff_w_q <= clamp_w(cfg_data);
					total_q <= CNT_W'(clamp_w(cfg_data)) * CNT_W'(eff_h_q);
				end
				itx_pkg::REG_IMAGE_HEIGHT: begin
					eff_h_q <= clamp_h(cfg_data);
					total_q <= CNT_W'(eff_w_q) * CNT_W'(clamp_h(cfg_data));
				end
				default: begin
				end
			endcase
		end
	end

	assign cmd     = itx_pkg::cmd_t'(s_tuser);
	assign s_fire  = s_tvalid && s_tready;
	assign full    = (recv_q == total_q);
	assign done    = (emit_q == total_q);
	assign emit_p1 = emit_q + CNT_W'(1);

	always_comb begin
		pix_take = 1'b0;
		emit_go  = 1'b0;
		case (cmd)
			itx_pkg::CMD_PIXEL: begin
				pix_take = s_fire && (!full || done);
				emit_go  = s_fire && !full && (recv_q >= CNT_W'(eff_w_q));
			end
			itx_pkg::CMD_DRAIN: begin
				emit_go = s_fire && full && !done;
			end
			default: begin
			end
		endcase
	end

	assign wr_addr_now = full ? '0 : wr_addr_q;

	// The row above sits eff_w + 1 entries behind the entry after the current pixel.
	assign above_diff = {1'b0, nx_addr_q} - (WIN_AW + 1)'(eff_w_q) - (WIN_AW + 1)'(1);
	assign above_addr = above_diff[WIN_AW]
		? WIN_AW'(above_diff + (WIN_AW + 1)'(WIN_D))
		: above_diff[WIN_AW-1:0];

	// The first pixel of an image has no row above, so the second port fetches the pixel itself.
	assign rd_b_addr = (emit_q == '0) ? '0 : above_addr;

	always_comb begin
		ctl_now.first    = (emit_q == '0);
		ctl_now.above_ok = (emit_q >= CNT_W'(eff_w_q));
		ctl_now.below_ok = (cmd == itx_pkg::CMD_PIXEL);
		ctl_now.prev_ok  = (emit_q != '0);
		ctl_now.next_ok  = (emit_p1 != total_q);
		ctl_now.last     = (emit_p1 == total_q);
		ctl_now.fwd      = (cmd == itx_pkg::CMD_PIXEL) && (nx_addr_q == wr_addr_now);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recv_q    <= '0;
			emit_q    <= '0;
			wr_addr_q <= '0;
			nx_addr_q <= WIN_AW'(1);
		end else if (cfg_we) begin
			recv_q    <= '0;
			emit_q    <= '0;
			wr_addr_q <= '0;
			nx_addr_q <= WIN_AW'(1);
		end else begin
			if (pix_take) begin
				if (full) begin
					recv_q    <= CNT_W'(1);
					emit_q    <= '0;
					wr_addr_q <= WIN_AW'(1);
					nx_addr_q <= WIN_AW'(1);
				end else begin
					recv_q    <= recv_q + CNT_W'(1);
					wr_addr_q <= win_inc(wr_addr_q);
				end
			end
			if (emit_go) begin
				emit_q    <= emit_p1;
				nx_addr_q <= win_inc(nx_addr_q);
			end
		end
	end

	itx_ram #(
		.WIDTH(8),
		.DEPTH(WIN_D)
	) u_win_a (
		.clk  (clk),
		.we   (pix_take),
		.waddr(wr_addr_now),
		.wdata(s_tdata[7:0]),
		.re   (s_fire),
		.raddr(nx_addr_q),
		.rdata(win_a_rd)
	);

	itx_ram #(
		.WIDTH(8),
		.DEPTH(WIN_D)
	) u_win_b (
		.clk  (clk),
		.we   (pix_take),
		.waddr(wr_addr_now),
		.wdata(s_tdata[7:0]),
		.re   (s_fire),
		.raddr(rd_b_addr),
		.rdata(win_b_rd)
	);

	assign adv1     = !v_s2 || m_tready;
	assign s_tready = !v_s1 || adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (s_fire) begin
				v_s1 <= emit_go;
			end else if (adv1) begin
				v_s1 <= 1'b0;
			end
			if (adv1) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			ctl_s1 <= ctl_now;
			pix_s1 <= s_tdata[7:0];
		end
		if (v_s1 && adv1) begin
			cur_q   <= cur_v;
			nxt_q   <= nxt_v;
			last_s2 <= ctl_s1.last;
		end
	end

	assign cur_v = ctl_s1.first ? win_b_rd : nxt_q;
	assign nxt_v = ctl_s1.fwd ? pix_s1 : win_a_rd;

	always_comb begin
		pal_idx = cur_v;
		if (cur_v == itx_pkg::HOLE_INDEX) begin
			if (ctl_s1.above_ok && (win_b_rd != itx_pkg::HOLE_INDEX)) begin
				pal_idx = win_b_rd;
			end else if (ctl_s1.below_ok && (pix_s1 != itx_pkg::HOLE_INDEX)) begin
				pal_idx = pix_s1;
			end else if (ctl_s1.prev_ok && (cur_q != itx_pkg::HOLE_INDEX)) begin
				pal_idx = cur_q;
			end else if (ctl_s1.next_ok && (nxt_v != itx_pkg::HOLE_INDEX)) begin
				pal_idx = nxt_v;
			end else begin
				pal_idx = '0;
			end
		end
	end

	// Palette entries are stored with red in the low byte, matching the result layout.
	itx_ram #(
		.WIDTH(itx_pkg::PAL_W),
		.DEPTH(256)
	) u_palette (
		.clk  (clk),
		.we   (s_fire && (cmd == itx_pkg::CMD_PALETTE)),
		.waddr(s_tdata[15:8]),
		.wdata(s_tdata[39:16]),
		.re   (adv1),
		.raddr(pal_idx),
		.rdata(m_tdata)
	);

	assign m_tvalid = v_s2;
	assign m_tlast  = last_s2;

endmodule

// ===== rtl/core/itx_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
module itx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for indexed_texel_expand_with_hole_fill.
// Needs itx_pkg and the block's RTL; drives the streams and the register port, scripts or
// predicts every RGB pixel from its own palette and index window, and compares in order.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_W = 1024;
	localparam int MAX_H = 1024;
	localparam int WIN_DEPTH = 2 * MAX_W + 1;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES = 300;
	localparam int RANDOM_REQUESTS = 600;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [1:0] CODE_WIDTH = 2'(itx_pkg::REG_IMAGE_WIDTH);
	localparam logic [1:0] CODE_HEIGHT = 2'(itx_pkg::REG_IMAGE_HEIGHT);

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic last_pixel;
	} pixel_t;

	typedef enum logic {ROW_REGISTER, ROW_REQUEST} row_kind_t;

	typedef struct packed {
		row_kind_t kind;
		logic [1:0] code;
		logic [itx_pkg::S_DATA_W-1:0] data;
		logic typed;
		logic has_pixel;
		pixel_t pixel;
	} script_row_t;

	localparam pixel_t NO_PIXEL = '0;

	// Request data reads blue, green, red, entry number, pixel index from the top byte down.
	localparam script_row_t SCRIPT [26] = '{
		'{ROW_REGISTER, CODE_WIDTH, 40'd0, 1'b0, 1'b0, NO_PIXEL},
		'{ROW_REGISTER, CODE_HEIGHT, 40'd0, 1'b0, 1'b0, NO_PIXEL},
		'{ROW_REQUEST, itx_pkg::CMD_PALETTE, 40'hff_ff_ff_00_00, 1'b1, 1'b0, NO_PIXEL},
		'{ROW_REQUEST, itx_pkg::CMD_PALETTE, 40'h00_00_00_ff_ff, 1'b1, 1'b0, NO_PIXEL},
		'{ROW_REQUEST, itx_pkg::CMD_PALETTE, 40'h03_02_01_01_00, 1'b1, 1'b0, NO_PIXEL},
		'{ROW_REQUEST, itx_pkg::CMD_PALETTE, 40'hfc_fd_fe_fe_00, 1'b1, 1'b0, NO_PIXEL},
		'{ROW_REQUEST, CMD_UNUSED, 40'hff_ff_ff_ff_ff, 1'b1, 1'b0, NO_PIXEL},
		'{ROW_REQUEST, itx_pkg::CMD_DRAIN, 40'd0, 1'b1, 1'b0, NO_PIXEL},
		'{ROW_REQUEST, itx_pkg::CMD_PIXEL, 40'h00_00_00_00_ff, 1'b1, 1'b0, NO_PIXEL},
		'{ROW_REQUEST, itx_pkg::CMD_PIXEL, 40'h00_00_00_00_01, 1'b1, 1'b0, NO_PIXEL},
		'{ROW_REQUEST, itx_pkg::CMD_DRAIN, 40'd0, 1'b1, 1'b1, '{8'hff, 8'hff, 8'hff, 1'b1}},
		'{ROW_REQUEST, itx_pkg::CMD_DRAIN, 40'd0, 1'b1, 1'b0, NO_PIXEL},
		'{ROW_REQUEST, itx_pkg::CMD_PIXEL, 40'h00_00_00_00_fe, 1'b1, 1'b0, NO_PIXEL},
		'{ROW_REQUEST, itx_pkg::CMD_DRAIN, 40'd0, 1'b1, 1'b1, '{8'hfe, 8'hfd, 8'hfc, 1'b1}},
		'{ROW_REGISTER, CODE_WIDTH, 40'd3, 1'b0, 1'b0, NO_PIXEL},
		'{ROW_REGISTER, CODE_HEIGHT, 40'd2, 1'b0, 1'b0, NO_PIXEL},
		'{ROW_REQUEST, itx_pkg::CMD_PIXEL, 40'h00_00_00_00_01, 1'b1, 1'b0, NO_PIXEL},
		'{ROW_REQUEST, itx_pkg::CMD_PIXEL, 40'h00_00_00_00_ff, 1'b1, 1'b0, NO_PIXEL},
		'{ROW_REQUEST, itx_pkg::CMD_PIXEL, 40'h00_00_00_00_fe, 1'b1, 1'b0, NO_PIXEL},
		'{ROW_REQUEST, itx_pkg::CMD_PIXEL, 40'h00_00_00_00_ff, 1'b1, 1'b1,
			'{8'h01, 8'h02, 8'h03, 1'b0}},
		'{ROW_REQUEST, itx_pkg::CMD_PIXEL, 40'h00_00_00_00_ff, 1'b0, 1'b0, NO_PIXEL},
		'{ROW_REQUEST, itx_pkg::CMD_PIXEL, 40'h00_00_00_00_00, 1'b1, 1'b1,
			'{8'hfe, 8'hfd, 8'hfc, 1'b0}},
		'{ROW_REQUEST, itx_pkg::CMD_DRAIN, 40'd0, 1'b0, 1'b0, NO_PIXEL},
		'{ROW_REQUEST, itx_pkg::CMD_DRAIN, 40'd0, 1'b0, 1'b0, NO_PIXEL},
		'{ROW_REQUEST, itx_pkg::CMD_DRAIN, 40'd0, 1'b1, 1'b1, '{8'hff, 8'hff, 8'hff, 1'b1}},
		'{ROW_REQUEST, itx_pkg::CMD_DRAIN, 40'd0, 1'b1, 1'b0, NO_PIXEL}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [itx_pkg::IDX_W-1:0] cfg_index = '0;
	logic [itx_pkg::CFG_W-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [itx_pkg::S_DATA_W-1:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [itx_pkg::M_DATA_W-1:0] m_tdata;
	logic m_tlast;

	logic [itx_pkg::CFG_W-1:0] width_reg = itx_pkg::CFG_W'(itx_pkg::RESET_WIDTH);
	logic [itx_pkg::CFG_W-1:0] height_reg = itx_pkg::CFG_W'(itx_pkg::RESET_HEIGHT);
	logic [itx_pkg::PAL_W-1:0] palette_rgb [256];
	logic [7:0] raw_window [WIN_DEPTH];
	int unsigned rx_count = 0;
	int unsigned tx_count = 0;

	pixel_t expected_pixels [$];
	int unsigned errors = 0;
	int unsigned requests_sent = 0;
	int unsigned pixels_seen = 0;
	int unsigned last_flags = 0;
	int unsigned src_idle_pct = 0;
	int unsigned sink_stall_pct = 0;
	int unsigned sink_hold_cycles = 0;

	indexed_texel_expand_with_hole_fill #(
		.MAX_WIDTH(MAX_W),
		.MAX_HEIGHT(MAX_H)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	always #5 clk = ~clk;

	function automatic void note_error(input string msg);
		errors++;
		if (errors <= 10) begin
			$display("ERROR at %0t: %s", $realtime, msg);
		end
	endfunction

	function automatic int unsigned clamp_dim(input logic [itx_pkg::CFG_W-1:0] v,
			input int unsigned lim);
		if (v == '0) begin
			return 1;
		end
		if (v > lim) begin
			return lim;
		end
		return 32'(v);
	endfunction

	function automatic logic [7:0] raw_at(input int unsigned pos);
		return raw_window[pos % WIN_DEPTH];
	endfunction

	// Expands the oldest pending pixel; a transparent index borrows the first opaque raw
	// neighbor above, below, before or after it in raster order, else entry 0.
	function automatic pixel_t expand_next_pixel(input int unsigned w, input int unsigned total);
		int unsigned e;
		logic [7:0] idx;
		pixel_t px;
		e = tx_count;
		idx = raw_at(e);
		if (idx == itx_pkg::HOLE_INDEX) begin
			if (e >= w && raw_at(e - w) != itx_pkg::HOLE_INDEX) begin
				idx = raw_at(e - w);
			end else if (e + w < total && raw_at(e + w) != itx_pkg::HOLE_INDEX) begin
				idx = raw_at(e + w);
			end else if (e > 0 && raw_at(e - 1) != itx_pkg::HOLE_INDEX) begin
				idx = raw_at(e - 1);
			end else if (e + 1 < total && raw_at(e + 1) != itx_pkg::HOLE_INDEX) begin
				idx = raw_at(e + 1);
			end else begin
				idx = 8'h00;
			end
		end
		{px.red, px.green, px.blue} = palette_rgb[idx];
		px.last_pixel = (e + 1 == total);
		tx_count = e + 1;
		return px;
	endfunction

	function automatic void predict_request(input logic [1:0] cmd,
			input logic [itx_pkg::S_DATA_W-1:0] data, output bit made, output pixel_t px);
		int unsigned w;
		int unsigned total;
		w = clamp_dim(width_reg, MAX_W);
		total = w * clamp_dim(height_reg, MAX_H);
		made = 1'b0;
		px = NO_PIXEL;
		case (cmd)
			itx_pkg::CMD_PALETTE: begin
				palette_rgb[data[15:8]] = {data[23:16], data[31:24], data[39:32]};
			end
			itx_pkg::CMD_PIXEL: begin
				if (!(rx_count >= total && tx_count < total)) begin
					if (rx_count >= total) begin
						rx_count = 0;
						tx_count = 0;
					end
					raw_window[rx_count % WIN_DEPTH] = data[7:0];
					rx_count++;
					if (tx_count + w < rx_count) begin
						px = expand_next_pixel(w, total);
						made = 1'b1;
					end
				end
			end
			itx_pkg::CMD_DRAIN: begin
				if (rx_count >= total && tx_count < total) begin
					px = expand_next_pixel(w, total);
					made = 1'b1;
				end
			end
			default: begin
			end
		endcase
	endfunction

	function automatic logic [itx_pkg::S_DATA_W-1:0] random_payload();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[itx_pkg::S_DATA_W-1:0];
	endfunction

	function automatic void set_idling(input int unsigned mode);
		case (mode % 4)
			0: begin
				src_idle_pct = 0;
				sink_stall_pct = 0;
			end
			1: begin
				src_idle_pct = 78;
				sink_stall_pct = 0;
			end
			2: begin
				src_idle_pct = 0;
				sink_stall_pct = 78;
			end
			default: begin
				src_idle_pct = 18;
				sink_stall_pct = 18;
			end
		endcase
	endfunction

	task automatic offer_request(input logic [1:0] cmd,
			input logic [itx_pkg::S_DATA_W-1:0] data, output bit made, output pixel_t px);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= data;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		requests_sent++;
		predict_request(cmd, data, made, px);
	endtask

	task automatic issue(input logic [1:0] cmd, input logic [itx_pkg::S_DATA_W-1:0] data);
		bit made;
		pixel_t px;
		offer_request(cmd, data, made, px);
		if (made) begin
			expected_pixels.push_back(px);
		end
	endtask

	// Waits until every predicted pixel has arrived, then lets the pipeline run dry.
	task automatic settle_outputs();
		int unsigned waited;
		waited = 0;
		s_tvalid <= 1'b0;
		while (expected_pixels.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		if (expected_pixels.size() != 0) begin
			note_error($sformatf("%0d expected pixels never arrived", expected_pixels.size()));
			expected_pixels.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [itx_pkg::IDX_W-1:0] idx,
			input logic [itx_pkg::CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		if (idx == itx_pkg::REG_IMAGE_WIDTH) begin
			width_reg = value;
		end else begin
			height_reg = value;
		end
		rx_count = 0;
		tx_count = 0;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Streams up to pixel_limit raster pixels of one image, with palette writes and noise
	// mixed in, and drains the last row when the image was sent whole.
	task automatic stream_image(input int unsigned w, input int unsigned total,
			input int unsigned hole_pct, input int unsigned pixel_limit);
		logic [itx_pkg::S_DATA_W-1:0] payload;
		int unsigned stop;
		stop = (pixel_limit < total) ? pixel_limit : total;
		for (int unsigned n = 0; n < stop; n++) begin
			if ($urandom_range(15) == 0) begin
				issue(itx_pkg::CMD_PALETTE, random_payload());
			end
			if ($urandom_range(39) == 0) begin
				issue($urandom_range(1) ? CMD_UNUSED : itx_pkg::CMD_DRAIN, random_payload());
			end
			payload = random_payload();
			payload[7:0] = ($urandom_range(99) < hole_pct) ? itx_pkg::HOLE_INDEX
				: 8'($urandom_range(254));
			issue(itx_pkg::CMD_PIXEL, payload);
		end
		if (stop == total) begin
			if ($urandom_range(3) == 0) begin
				issue(itx_pkg::CMD_PIXEL, random_payload());
			end
			repeat (w) issue(itx_pkg::CMD_DRAIN, random_payload());
			if ($urandom_range(3) == 0) begin
				issue(itx_pkg::CMD_DRAIN, random_payload());
			end
		end
	endtask

	task automatic image_phase();
		logic [itx_pkg::CFG_W-1:0] wv;
		logic [itx_pkg::CFG_W-1:0] hv;
		int unsigned w;
		int unsigned total;
		int unsigned count;
		case ($urandom_range(7))
			0: wv = '0;
			1: wv = itx_pkg::CFG_W'(1);
			2: wv = itx_pkg::CFG_W'($urandom_range(16, 10));
			default: wv = itx_pkg::CFG_W'($urandom_range(8, 2));
		endcase
		case ($urandom_range(5))
			0: hv = '0;
			1: hv = itx_pkg::CFG_W'(1);
			default: hv = itx_pkg::CFG_W'($urandom_range(6, 1));
		endcase
		settle_outputs();
		if ($urandom_range(1)) begin
			write_register(itx_pkg::REG_IMAGE_WIDTH, wv);
			write_register(itx_pkg::REG_IMAGE_HEIGHT, hv);
		end else begin
			write_register(itx_pkg::REG_IMAGE_HEIGHT, hv);
			write_register(itx_pkg::REG_IMAGE_WIDTH, wv);
		end
		w = clamp_dim(wv, MAX_W);
		total = w * clamp_dim(hv, MAX_H);
		count = $urandom_range(3, 1);
		for (int unsigned k = 0; k < count; k++) begin
			stream_image(w, total, ($urandom_range(3) == 0) ? 95 : $urandom_range(50),
				(k + 1 == count && $urandom_range(4) == 0) ? $urandom_range(total) : total);
		end
	endtask

	always @(posedge clk) begin
		if (sink_hold_cycles > 0) begin
			m_tready <= 1'b0;
			sink_hold_cycles--;
		end else begin
			m_tready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	always @(posedge clk) begin : check_pixels
		pixel_t want;
		pixel_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tlast};
			pixels_seen++;
			if (m_tlast) begin
				last_flags++;
			end
			if (expected_pixels.size() == 0) begin
				note_error($sformatf("unexpected pixel rgb=%02h%02h%02h last=%b",
					got.red, got.green, got.blue, got.last_pixel));
			end else begin
				want = expected_pixels.pop_front();
				if (got !== want) begin
					note_error($sformatf("pixel %0d: want %02h%02h%02h/%b, got %02h%02h%02h/%b",
						pixels_seen, want.red, want.green, want.blue, want.last_pixel,
						got.red, got.green, got.blue, got.last_pixel));
				end
			end
		end
	end

	initial begin : watchdog
		#3_000_000;
		$display("Timeout with %0d pixels still expected", expected_pixels.size());
		$display("DONE: errors detected");
		$finish;
	end

	initial begin : stimulus
		bit made;
		pixel_t px;
		logic [itx_pkg::S_DATA_W-1:0] payload;
		int unsigned random_start;
		int unsigned phase;
		foreach (palette_rgb[i]) begin
			palette_rgb[i] = '0;
		end
		foreach (raw_window[i]) begin
			raw_window[i] = '0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (SCRIPT[i]) begin
			if (SCRIPT[i].kind == ROW_REGISTER) begin
				settle_outputs();
				write_register(SCRIPT[i].code[itx_pkg::IDX_W-1:0],
					SCRIPT[i].data[itx_pkg::CFG_W-1:0]);
			end else begin
				offer_request(SCRIPT[i].code, SCRIPT[i].data, made, px);
				if (SCRIPT[i].typed) begin
					if (SCRIPT[i].has_pixel) begin
						expected_pixels.push_back(SCRIPT[i].pixel);
					end
				end else if (made) begin
					expected_pixels.push_back(px);
				end
			end
		end

		// Every entry a pixel can select gets a color before random images start.
		settle_outputs();
		set_idling(0);
		for (int e = 0; e < 256; e++) begin
			payload = random_payload();
			payload[15:8] = 8'(e);
			issue(itx_pkg::CMD_PALETTE, payload);
		end

		random_start = requests_sent;
		phase = 0;
		while (requests_sent - random_start < RANDOM_REQUESTS) begin
			set_idling(phase);
			if (phase == 6) begin
				settle_outputs();
				write_register(itx_pkg::REG_IMAGE_WIDTH, itx_pkg::CFG_W'(4));
				write_register(itx_pkg::REG_IMAGE_HEIGHT, itx_pkg::CFG_W'(16));
				sink_hold_cycles = HOLD_CYCLES;
				stream_image(4, 64, 30, 64);
			end else begin
				image_phase();
			end
			phase++;
		end

		// Oversized registers saturate; one long row and three more pixels show the full width.
		settle_outputs();
		set_idling(0);
		write_register(itx_pkg::REG_IMAGE_WIDTH, itx_pkg::CFG_W'(2047));
		write_register(itx_pkg::REG_IMAGE_HEIGHT, itx_pkg::CFG_W'(3));
		stream_image(MAX_W, MAX_W * 3, 20, MAX_W + 3);
		settle_outputs();
		write_register(itx_pkg::REG_IMAGE_WIDTH, itx_pkg::CFG_W'(1));
		write_register(itx_pkg::REG_IMAGE_HEIGHT, itx_pkg::CFG_W'(2047));
		stream_image(1, MAX_H, 40, 40);
		settle_outputs();

		$display("Covered %0d requests in %0d random phases; %0d pixels, %0d image ends.",
			requests_sent, phase, pixels_seen, last_flags);
		$display("Sizes ran from 1x1 to saturated %0d-pixel rows, with a %0d-cycle hold-off.",
			MAX_W, HOLD_CYCLES);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/itx_pkg.sv
rtl/core/itx_ram.sv
rtl/core/indexed_texel_expand_with_hole_fill.sv
tb/tb_top.sv
